// ----- rtl/sat_pkg.sv -----
package sat_pkg;

    localparam int ID_W        = 10;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int WEIGHT_IN_W = 16;
    localparam int DEG_OUT_W   = 6;
    localparam int HEC_W       = 16;

    localparam int NODES_DEF       = 1024;
    localparam int MAX_DEGREE_DEF  = 32;
    localparam int WEIGHT_BITS_DEF = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_SELF = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DEG_A,
        S_DEG_B,
        S_DEG_BW,
        S_DISPATCH,
        S_SEEK_INIT,
        S_SEEK_RD,
        S_SEEK_CMP,
        S_SEEK_END,
        S_DN_RD,
        S_DN_WR,
        S_INS_INIT,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_DEG_DEC,
        S_DEG_INC,
        S_FINISH
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_RD_DEG_A,
        OP_RD_DEG_B,
        OP_CAP_DEG_B,
        OP_SEEK_INIT,
        OP_SEEK_RD,
        OP_SEEK_STEP,
        OP_SEEK_DONE,
        OP_DN_RD,
        OP_DN_WR,
        OP_INS_INIT,
        OP_UP_RD,
        OP_UP_WR,
        OP_PUT,
        OP_DEG_DEC,
        OP_DEG_INC,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    side;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  in_range;
        logic  same;
        logic  p_lt_deg;
        logic  k1_lt_deg;
        logic  k_gt_p;
        logic  id_lt;
        logic  hit_now;
        logic  hit_a;
        logic  full;
        logic  clr_last;
        logic  out_free;
    } dp_stat_t;

endpackage

// ----- rtl/sat_if.sv -----
interface sat_req_if;
    logic                           valid;
    logic                           ready;
    logic [sat_pkg::KIND_W-1:0]     kind;
    logic [sat_pkg::ID_W-1:0]       node_from;
    logic [sat_pkg::ID_W-1:0]       node_to;
    logic [sat_pkg::WEIGHT_IN_W-1:0] weight;

    modport source (output valid, kind, node_from, node_to, weight, input ready);
    modport sink (input valid, kind, node_from, node_to, weight, output ready);
endinterface

interface sat_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sat_pkg::STATUS_W-1:0]    status;
    logic [sat_pkg::WEIGHT_IN_W-1:0] weight_out;
    logic [sat_pkg::DEG_OUT_W-1:0]   degree_out;
    logic [sat_pkg::HEC_W-1:0]       half_edge_total;

    modport source (output valid, status, weight_out, degree_out, half_edge_total, input ready);
    modport sink (input valid, status, weight_out, degree_out, half_edge_total, output ready);
endinterface

// ----- rtl/sorted_adjacency_table_top.sv -----
// Undirected weighted graph store: per-node neighbor lists sorted by id, up to
// MAX_DEGREE entries each, kept in one single-port entry RAM plus a degree RAM.
// After reset the degree RAM is cleared one node per cycle, so no request is
// taken until every node is cleared. Every walk or shift step is a read of the
// entry RAM, then a compare or a write back. Add walks both lists and then
// shifts each tail up by one entry. Remove walks each list and shifts its tail
// down. One request is in flight at a time; a finished word waits in the output
// register while the next request is taken.
module sorted_adjacency_table_top #(
    parameter int NODES       = sat_pkg::NODES_DEF,
    parameter int MAX_DEGREE  = sat_pkg::MAX_DEGREE_DEF,
    parameter int WEIGHT_BITS = sat_pkg::WEIGHT_BITS_DEF
) (
    input logic  clk,
    input logic  rst_n,
    sat_req_if.sink   req,
    sat_rsp_if.source rsp
);

    sat_pkg::dp_cmd_t  cmd;
    sat_pkg::dp_stat_t stat;

    sat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sat_dp #(
        .NODES       (NODES),
        .MAX_DEGREE  (MAX_DEGREE),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .kind            (req.kind),
        .node_from       (req.node_from),
        .node_to         (req.node_to),
        .weight          (req.weight),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .status          (rsp.status),
        .weight_out      (rsp.weight_out),
        .degree_out      (rsp.degree_out),
        .half_edge_total (rsp.half_edge_total)
    );

endmodule

// ----- rtl/sat_ctrl.sv -----
module sat_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sat_pkg::dp_stat_t stat,
    output sat_pkg::dp_cmd_t  cmd
);

    sat_pkg::state_t  state_reg, state_next;
    logic             side_reg, side_next;
    sat_pkg::status_t res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sat_pkg::S_CLEAR;
            side_reg  <= 1'b0;
            res_reg   <= sat_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        res_next   = res_reg;
        case (state_reg)
            sat_pkg::S_CLEAR:
                if (stat.clr_last)
                    state_next = sat_pkg::S_IDLE;
            sat_pkg::S_IDLE:
                if (in_valid)
                    state_next = sat_pkg::S_DEG_A;
            sat_pkg::S_DEG_A:  state_next = sat_pkg::S_DEG_B;
            sat_pkg::S_DEG_B:  state_next = sat_pkg::S_DEG_BW;
            sat_pkg::S_DEG_BW: state_next = sat_pkg::S_DISPATCH;
            sat_pkg::S_DISPATCH:
            begin
                if (!stat.in_range || stat.kind == sat_pkg::KIND_NONE)
                begin
                    res_next   = sat_pkg::ST_MISS;
                    state_next = sat_pkg::S_FINISH;
                end
                else if (stat.kind != sat_pkg::KIND_LOOKUP && stat.same)
                begin
                    res_next   = sat_pkg::ST_SELF;
                    state_next = sat_pkg::S_FINISH;
                end
                else
                begin
                    side_next  = 1'b0;
                    state_next = sat_pkg::S_SEEK_INIT;
                end
            end
            sat_pkg::S_SEEK_INIT: state_next = sat_pkg::S_SEEK_RD;
            sat_pkg::S_SEEK_RD:
                state_next = stat.p_lt_deg ? sat_pkg::S_SEEK_CMP : sat_pkg::S_SEEK_END;
            sat_pkg::S_SEEK_CMP:
                state_next = stat.id_lt ? sat_pkg::S_SEEK_RD : sat_pkg::S_SEEK_END;
            sat_pkg::S_SEEK_END:
            begin
                case (stat.kind)
                    sat_pkg::KIND_LOOKUP:
                    begin
                        res_next   = stat.hit_now ? sat_pkg::ST_OK : sat_pkg::ST_MISS;
                        state_next = sat_pkg::S_FINISH;
                    end
                    sat_pkg::KIND_REMOVE:
                    begin
                        if (stat.hit_now)
                        begin
                            res_next   = sat_pkg::ST_OK;
                            state_next = sat_pkg::S_DN_RD;
                        end
                        else
                        begin
                            res_next   = side_reg ? sat_pkg::ST_OK : sat_pkg::ST_MISS;
                            state_next = sat_pkg::S_FINISH;
                        end
                    end
                    sat_pkg::KIND_ADD:
                    begin
                        if (!side_reg)
                        begin
                            side_next  = 1'b1;
                            state_next = sat_pkg::S_SEEK_INIT;
                        end
                        else if (stat.hit_a || stat.hit_now)
                        begin
                            res_next   = sat_pkg::ST_MISS;
                            state_next = sat_pkg::S_FINISH;
                        end
                        else if (stat.full)
                        begin
                            res_next   = sat_pkg::ST_FULL;
                            state_next = sat_pkg::S_FINISH;
                        end
                        else
                        begin
                            side_next  = 1'b0;
                            state_next = sat_pkg::S_INS_INIT;
                        end
                    end
                    default:
                    begin
                        res_next   = sat_pkg::ST_MISS;
                        state_next = sat_pkg::S_FINISH;
                    end
                endcase
            end
            sat_pkg::S_DN_RD:
                state_next = stat.k1_lt_deg ? sat_pkg::S_DN_WR : sat_pkg::S_DEG_DEC;
            sat_pkg::S_DN_WR: state_next = sat_pkg::S_DN_RD;
            sat_pkg::S_DEG_DEC:
            begin
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = sat_pkg::S_SEEK_INIT;
                end
                else
                begin
                    res_next   = sat_pkg::ST_OK;
                    state_next = sat_pkg::S_FINISH;
                end
            end
            sat_pkg::S_INS_INIT: state_next = sat_pkg::S_UP_RD;
            sat_pkg::S_UP_RD:
                state_next = stat.k_gt_p ? sat_pkg::S_UP_WR : sat_pkg::S_PUT;
            sat_pkg::S_UP_WR: state_next = sat_pkg::S_UP_RD;
            sat_pkg::S_PUT:   state_next = sat_pkg::S_DEG_INC;
            sat_pkg::S_DEG_INC:
            begin
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    state_next = sat_pkg::S_INS_INIT;
                end
                else
                begin
                    res_next   = sat_pkg::ST_OK;
                    state_next = sat_pkg::S_FINISH;
                end
            end
            sat_pkg::S_FINISH:
                if (stat.out_free)
                    state_next = sat_pkg::S_IDLE;
            default: state_next = sat_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.op     = sat_pkg::OP_NONE;
        cmd.side   = side_reg;
        cmd.status = res_reg;
        case (state_reg)
            sat_pkg::S_CLEAR: cmd.op = sat_pkg::OP_CLEAR;
            sat_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = sat_pkg::OP_LOAD;
            end
            sat_pkg::S_DEG_A:     cmd.op = sat_pkg::OP_RD_DEG_A;
            sat_pkg::S_DEG_B:     cmd.op = sat_pkg::OP_RD_DEG_B;
            sat_pkg::S_DEG_BW:    cmd.op = sat_pkg::OP_CAP_DEG_B;
            sat_pkg::S_SEEK_INIT: cmd.op = sat_pkg::OP_SEEK_INIT;
            sat_pkg::S_SEEK_RD:
                if (stat.p_lt_deg)
                    cmd.op = sat_pkg::OP_SEEK_RD;
            sat_pkg::S_SEEK_CMP:
                if (stat.id_lt)
                    cmd.op = sat_pkg::OP_SEEK_STEP;
            sat_pkg::S_SEEK_END:  cmd.op = sat_pkg::OP_SEEK_DONE;
            sat_pkg::S_DN_RD:
                if (stat.k1_lt_deg)
                    cmd.op = sat_pkg::OP_DN_RD;
            sat_pkg::S_DN_WR:     cmd.op = sat_pkg::OP_DN_WR;
            sat_pkg::S_INS_INIT:  cmd.op = sat_pkg::OP_INS_INIT;
            sat_pkg::S_UP_RD:
                if (stat.k_gt_p)
                    cmd.op = sat_pkg::OP_UP_RD;
            sat_pkg::S_UP_WR:     cmd.op = sat_pkg::OP_UP_WR;
            sat_pkg::S_PUT:       cmd.op = sat_pkg::OP_PUT;
            sat_pkg::S_DEG_DEC:   cmd.op = sat_pkg::OP_DEG_DEC;
            sat_pkg::S_DEG_INC:   cmd.op = sat_pkg::OP_DEG_INC;
            sat_pkg::S_FINISH:
                if (stat.out_free)
                    cmd.op = sat_pkg::OP_FINISH;
            default: cmd.op = sat_pkg::OP_NONE;
        endcase
    end

endmodule

// ----- rtl/sat_dp.sv -----
module sat_dp #(
    parameter int NODES       = sat_pkg::NODES_DEF,
    parameter int MAX_DEGREE  = sat_pkg::MAX_DEGREE_DEF,
    parameter int WEIGHT_BITS = sat_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sat_pkg::dp_cmd_t                  cmd,
    output sat_pkg::dp_stat_t                 stat,
    input  logic [sat_pkg::KIND_W-1:0]        kind,
    input  logic [sat_pkg::ID_W-1:0]          node_from,
    input  logic [sat_pkg::ID_W-1:0]          node_to,
    input  logic [sat_pkg::WEIGHT_IN_W-1:0]   weight,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sat_pkg::STATUS_W-1:0]      status,
    output logic [sat_pkg::WEIGHT_IN_W-1:0]   weight_out,
    output logic [sat_pkg::DEG_OUT_W-1:0]     degree_out,
    output logic [sat_pkg::HEC_W-1:0]         half_edge_total
);

    localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH   = NODES * MAX_DEGREE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENT_W   = sat_pkg::ID_W + WEIGHT_BITS;

    logic [ENT_W-1:0] ent_mem [DEPTH];
    logic [DEG_W-1:0] deg_mem [NODES];

    sat_pkg::kind_t               kind_reg;
    logic [sat_pkg::ID_W-1:0]     a_reg, b_reg;
    logic [WEIGHT_BITS-1:0]       w_reg, wfound_reg;
    logic [DEG_W-1:0]             deg_a_reg, deg_b_reg, deg_cur_reg;
    logic [DEG_W-1:0]             p_reg, k_reg, pa_reg, pb_reg;
    logic                         hit_a_reg;
    logic [ADDR_W-1:0]            base_reg;
    logic [ENT_W-1:0]             rd_ent_reg;
    logic [DEG_W-1:0]             rd_deg_reg;
    logic [NODE_W-1:0]            clr_reg;
    logic [sat_pkg::HEC_W-1:0]    hec_reg;
    logic                         out_valid_reg;
    logic [sat_pkg::STATUS_W-1:0] out_status_reg;
    logic [sat_pkg::WEIGHT_IN_W-1:0] out_weight_reg;
    logic [sat_pkg::DEG_OUT_W-1:0]   out_deg_reg;
    logic [sat_pkg::HEC_W-1:0]       out_hec_reg;

    logic [NODE_W-1:0]        a_idx, b_idx, node_sel;
    logic [sat_pkg::ID_W-1:0] target;
    logic                     a_ok, b_ok;
    logic [sat_pkg::ID_W-1:0] rd_id;
    logic [DEG_W-1:0]         k_inc;
    logic                     ent_we, ent_re, deg_we, deg_re;
    logic [ADDR_W-1:0]        ent_addr;
    logic [ENT_W-1:0]         ent_wdata;
    logic [NODE_W-1:0]        deg_addr;
    logic [DEG_W-1:0]         deg_wdata;
    logic                     side;

    assign side     = cmd.side;
    assign a_idx    = NODE_W'(a_reg);
    assign b_idx    = NODE_W'(b_reg);
    assign node_sel = side ? b_idx : a_idx;
    assign target   = side ? a_reg : b_reg;
    assign a_ok     = 32'(a_reg) < 32'(NODES);
    assign b_ok     = 32'(b_reg) < 32'(NODES);
    assign rd_id    = rd_ent_reg[ENT_W-1 -: sat_pkg::ID_W];
    assign k_inc    = k_reg + DEG_W'(1);

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.in_range  = a_ok && b_ok;
        stat.same      = a_reg == b_reg;
        stat.p_lt_deg  = p_reg < deg_cur_reg;
        stat.k1_lt_deg = k_inc < deg_cur_reg;
        stat.k_gt_p    = k_reg > p_reg;
        stat.id_lt     = rd_id < target;
        stat.hit_now   = (p_reg < deg_cur_reg) && (rd_id == target);
        stat.hit_a     = hit_a_reg;
        stat.full      = (deg_a_reg >= DEG_W'(MAX_DEGREE)) || (deg_b_reg >= DEG_W'(MAX_DEGREE));
        stat.clr_last  = clr_reg == NODE_W'(NODES - 1);
        stat.out_free  = !out_valid_reg || out_ready;
    end

    // memory port steering
    always_comb
    begin
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_addr  = base_reg + ADDR_W'(p_reg);
        ent_wdata = rd_ent_reg;
        deg_we    = 1'b0;
        deg_re    = 1'b0;
        deg_addr  = node_sel;
        deg_wdata = deg_cur_reg;
        case (cmd.op)
            sat_pkg::OP_CLEAR:
            begin
                deg_we    = 1'b1;
                deg_addr  = clr_reg;
                deg_wdata = '0;
            end
            sat_pkg::OP_RD_DEG_A:
            begin
                deg_re   = 1'b1;
                deg_addr = a_idx;
            end
            sat_pkg::OP_RD_DEG_B:
            begin
                deg_re   = 1'b1;
                deg_addr = b_idx;
            end
            sat_pkg::OP_SEEK_RD: ent_re = 1'b1;
            sat_pkg::OP_DN_RD:
            begin
                ent_re   = 1'b1;
                ent_addr = base_reg + ADDR_W'(k_inc);
            end
            sat_pkg::OP_UP_RD:
            begin
                ent_re   = 1'b1;
                ent_addr = base_reg + ADDR_W'(k_reg - DEG_W'(1));
            end
            sat_pkg::OP_DN_WR, sat_pkg::OP_UP_WR:
            begin
                ent_we   = 1'b1;
                ent_addr = base_reg + ADDR_W'(k_reg);
            end
            sat_pkg::OP_PUT:
            begin
                ent_we    = 1'b1;
                ent_wdata = {target, w_reg};
            end
            sat_pkg::OP_DEG_DEC:
            begin
                deg_we    = 1'b1;
                deg_wdata = deg_cur_reg - DEG_W'(1);
            end
            sat_pkg::OP_DEG_INC:
            begin
                deg_we    = 1'b1;
                deg_wdata = deg_cur_reg + DEG_W'(1);
            end
            default: ent_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_addr] <= ent_wdata;
        if (ent_re)
            rd_ent_reg <= ent_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            deg_mem[deg_addr] <= deg_wdata;
        if (deg_re)
            rd_deg_reg <= deg_mem[deg_addr];
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            sat_pkg::OP_LOAD:
            begin
                kind_reg <= sat_pkg::kind_t'(kind);
                a_reg    <= node_from;
                b_reg    <= node_to;
                w_reg    <= WEIGHT_BITS'(weight);
            end
            sat_pkg::OP_RD_DEG_B:  deg_a_reg <= a_ok ? rd_deg_reg : '0;
            sat_pkg::OP_CAP_DEG_B: deg_b_reg <= rd_deg_reg;
            sat_pkg::OP_SEEK_INIT:
            begin
                base_reg    <= ADDR_W'(node_sel) * ADDR_W'(MAX_DEGREE);
                deg_cur_reg <= side ? deg_b_reg : deg_a_reg;
                p_reg       <= '0;
            end
            sat_pkg::OP_SEEK_STEP: p_reg <= p_reg + DEG_W'(1);
            sat_pkg::OP_SEEK_DONE:
            begin
                k_reg <= p_reg;
                if (side)
                begin
                    pb_reg <= p_reg;
                end
                else
                begin
                    pa_reg     <= p_reg;
                    hit_a_reg  <= stat.hit_now;
                    wfound_reg <= rd_ent_reg[WEIGHT_BITS-1:0];
                end
            end
            sat_pkg::OP_INS_INIT:
            begin
                base_reg    <= ADDR_W'(node_sel) * ADDR_W'(MAX_DEGREE);
                deg_cur_reg <= side ? deg_b_reg : deg_a_reg;
                p_reg       <= side ? pb_reg : pa_reg;
                k_reg       <= side ? deg_b_reg : deg_a_reg;
            end
            sat_pkg::OP_DN_WR: k_reg <= k_inc;
            sat_pkg::OP_UP_WR: k_reg <= k_reg - DEG_W'(1);
            sat_pkg::OP_DEG_DEC:
                if (side)
                    deg_b_reg <= deg_cur_reg - DEG_W'(1);
                else
                    deg_a_reg <= deg_cur_reg - DEG_W'(1);
            sat_pkg::OP_DEG_INC:
                if (side)
                    deg_b_reg <= deg_cur_reg + DEG_W'(1);
                else
                    deg_a_reg <= deg_cur_reg + DEG_W'(1);
            default: k_reg <= k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            hec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == sat_pkg::OP_CLEAR)
                clr_reg <= clr_reg + NODE_W'(1);
            if (cmd.op == sat_pkg::OP_DEG_INC)
                hec_reg <= hec_reg + sat_pkg::HEC_W'(1);
            else if (cmd.op == sat_pkg::OP_DEG_DEC)
                hec_reg <= hec_reg - sat_pkg::HEC_W'(1);
            if (cmd.op == sat_pkg::OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == sat_pkg::OP_FINISH)
        begin
            out_status_reg <= cmd.status;
            out_weight_reg <= (cmd.status == sat_pkg::ST_OK && kind_reg != sat_pkg::KIND_ADD)
                              ? sat_pkg::WEIGHT_IN_W'(wfound_reg) : '0;
            out_deg_reg    <= sat_pkg::DEG_OUT_W'(deg_a_reg);
            out_hec_reg    <= hec_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign weight_out      = out_weight_reg;
    assign degree_out      = out_deg_reg;
    assign half_edge_total = out_hec_reg;

    a_up_wr_above_p: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sat_pkg::OP_UP_WR) |-> (k_reg > p_reg))
        else $error("shift-up write at or below insert point");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sat_pkg::OP_DEG_INC) |-> (deg_cur_reg < DEG_W'(MAX_DEGREE)))
        else $error("degree increment past list capacity");

    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sat_pkg::OP_DEG_DEC) |-> (deg_cur_reg != '0))
        else $error("degree decrement of empty list");

    a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == sat_pkg::OP_FINISH) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

endmodule

// ----- tb/sat_tb_if.sv -----
// Interfaces come from the RTL; this file only holds the response struct and the scoreboard class.
package sat_tb_pkg;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] weight_out;
        logic [5:0]  degree_out;
        logic [15:0] half_edge_total;
    } graph_rsp_t;

    class graph_scoreboard;
        localparam int NN = 1024;
        localparam int MD = 32;
        logic [9:0]  nbr_id [NN][MD];
        logic [15:0] nbr_w  [NN][MD];
        int          deg    [NN];
        int          halves;
        graph_rsp_t  pending [$];
        int          errors;

        function new();
            foreach (deg[i]) deg[i] = 0;
            halves = 0;
            errors = 0;
        endfunction

        function int find_pos(int node, int target, output bit hit);
            int p;
            p = 0;
            while (p < deg[node] && nbr_id[node][p] < target) p++;
            hit = (p < deg[node]) && (nbr_id[node][p] == target);
            return p;
        endfunction

        function void insert_half(int node, int target, logic [15:0] w);
            bit h;
            int p;
            p = find_pos(node, target, h);
            for (int k = deg[node]; k > p; k--)
            begin
                nbr_id[node][k] = nbr_id[node][k-1];
                nbr_w[node][k]  = nbr_w[node][k-1];
            end
            nbr_id[node][p] = 10'(target);
            nbr_w[node][p]  = w;
            deg[node]++;
            halves++;
        endfunction

        function logic [15:0] drop_half(int node, int target);
            bit h;
            int p;
            logic [15:0] w;
            p = find_pos(node, target, h);
            if (!h) return '0;
            w = nbr_w[node][p];
            for (int k = p; k + 1 < deg[node]; k++)
            begin
                nbr_id[node][k] = nbr_id[node][k+1];
                nbr_w[node][k]  = nbr_w[node][k+1];
            end
            deg[node]--;
            if (halves > 0) halves--;
            return w;
        endfunction

        function void note_request(logic [1:0] kind, int a, int b, logic [15:0] w);
            graph_rsp_t r;
            bit h1, h2;
            int p;
            r.status = sat_pkg::ST_MISS;
            r.weight_out = '0;
            if (kind == sat_pkg::KIND_ADD)
            begin
                if (a == b) r.status = sat_pkg::ST_SELF;
                else
                begin
                    void'(find_pos(a, b, h1));
                    void'(find_pos(b, a, h2));
                    if (h1 || h2) r.status = sat_pkg::ST_MISS;
                    else if (deg[a] >= MD || deg[b] >= MD) r.status = sat_pkg::ST_FULL;
                    else
                    begin
                        insert_half(a, b, w);
                        insert_half(b, a, w);
                        r.status = sat_pkg::ST_OK;
                    end
                end
            end
            else if (kind == sat_pkg::KIND_REMOVE)
            begin
                if (a == b) r.status = sat_pkg::ST_SELF;
                else
                begin
                    void'(find_pos(a, b, h1));
                    if (h1)
                    begin
                        r.weight_out = drop_half(a, b);
                        void'(drop_half(b, a));
                        r.status = sat_pkg::ST_OK;
                    end
                end
            end
            else if (kind == sat_pkg::KIND_LOOKUP)
            begin
                p = find_pos(a, b, h1);
                if (h1)
                begin
                    r.weight_out = nbr_w[a][p];
                    r.status = sat_pkg::ST_OK;
                end
            end
            r.degree_out = deg[a][5:0];
            r.half_edge_total = halves[15:0];
            pending = {pending, r};
        endfunction

        function void check_response(graph_rsp_t got);
            graph_rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word st=%0d w=%0d", $time, got.status, got.weight_out);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
                errors++;
            end
            if (got.weight_out !== e.weight_out)
            begin
                $display("%0t: weight exp %0d got %0d", $time, e.weight_out, got.weight_out);
                errors++;
            end
            if (got.degree_out !== e.degree_out)
            begin
                $display("%0t: degree exp %0d got %0d", $time, e.degree_out, got.degree_out);
                errors++;
            end
            if (got.half_edge_total !== e.half_edge_total)
            begin
                $display("%0t: halves exp %0d got %0d", $time, e.half_edge_total,
                         got.half_edge_total);
                errors++;
            end
        endfunction
    endclass
endpackage

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    sat_req_if req();
    sat_rsp_if rsp();

    sorted_adjacency_table_top dut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    sat_tb_pkg::graph_scoreboard sb = new();
    bit   hold_rsp = 0;
    bit   sender_done = 0;
    int   hub;

    initial
    begin
        req.valid = 0;
        req.kind = 0;
        req.node_from = 0;
        req.node_to = 0;
        req.weight = 0;
        rsp.ready = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(logic [1:0] kind, logic [9:0] a, logic [9:0] b,
                                logic [15:0] w);
        req.valid <= 1;
        req.kind <= kind;
        req.node_from <= a;
        req.node_to <= b;
        req.weight <= w;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sb.note_request(kind, a, b, w);
    endtask

    task automatic idle_req(int n);
        if (n > 0)
        begin
            req.valid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // response side: sample at edge, random stalls, long hold when asked
    initial
    begin
        sat_tb_pkg::graph_rsp_t got;
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got.status = rsp.status;
                got.weight_out = rsp.weight_out;
                got.degree_out = rsp.degree_out;
                got.half_edge_total = rsp.half_edge_total;
                sb.check_response(got);
            end
            if (hold_rsp) rsp.ready <= 0;
            else if (stall > 0)
            begin
                stall--;
                rsp.ready <= 0;
            end
            else
            begin
                stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                rsp.ready <= (stall == 0);
            end
        end
    end

    function automatic logic [9:0] pick_node();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 10'($urandom_range(0, 15));
        if (r < 8) return 10'($urandom_range(0, 1023));
        return (r == 8) ? 10'd0 : 10'd1023;
    endfunction

    initial
    begin
        int k;
        logic [1:0] kind;
        logic [9:0] a, b;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed
        send_request(sat_pkg::KIND_ADD, 0, 1023, 16'hFFFF);
        send_request(sat_pkg::KIND_ADD, 1023, 0, 16'h1234);
        send_request(sat_pkg::KIND_LOOKUP, 1023, 0, 0);
        send_request(sat_pkg::KIND_ADD, 5, 5, 16'h0001);
        send_request(sat_pkg::KIND_REMOVE, 5, 5, 0);
        send_request(sat_pkg::KIND_LOOKUP, 5, 5, 0);
        send_request(sat_pkg::KIND_ADD, 3, 7, 16'h0000);
        send_request(sat_pkg::KIND_LOOKUP, 7, 3, 0);
        send_request(sat_pkg::KIND_REMOVE, 3, 9, 0);
        send_request(sat_pkg::KIND_LOOKUP, 3, 9, 0);
        send_request(sat_pkg::KIND_NONE, 3, 7, 16'hAAAA);
        send_request(sat_pkg::KIND_REMOVE, 7, 3, 0);
        send_request(sat_pkg::KIND_REMOVE, 7, 3, 0);
        send_request(sat_pkg::KIND_REMOVE, 0, 1023, 16'h5555);
        // fill node hub to max degree, then hit full on both sides
        hub = 100;
        for (int i = 0; i < 32; i++)
            send_request(sat_pkg::KIND_ADD, 10'(hub), 10'(200 + i * 3), 16'(i * 77));
        send_request(sat_pkg::KIND_ADD, 10'(hub), 500, 16'h7777);
        send_request(sat_pkg::KIND_ADD, 501, 10'(hub), 16'h7777);
        wait_drained();

        // long response hold while requests keep coming
        fork
            begin
                hold_rsp = 1;
                repeat (600) @(posedge clk);
                hold_rsp = 0;
            end
            for (int i = 0; i < 20; i++)
                send_request(sat_pkg::KIND_LOOKUP, 10'(hub), 10'(200 + i * 3), 0);
        join
        wait_drained();

        k = 0;
        while (k < 1250)
        begin
            kind = ($urandom_range(0, 9) < 5) ? sat_pkg::KIND_ADD :
                   (($urandom_range(0, 1) != 0) ? sat_pkg::KIND_REMOVE : sat_pkg::KIND_LOOKUP);
            if ($urandom_range(0, 49) == 0) kind = sat_pkg::KIND_NONE;
            a = pick_node();
            b = ($urandom_range(0, 19) == 0) ? a : pick_node();
            if ($urandom_range(0, 9) == 0) a = 10'(hub);
            send_request(kind, a, b, 16'($urandom()));
            idle_req(gap_len());
            k++;
            if (k == 600) wait_drained();
        end
        sender_done = 1;
        wait_drained();
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
